@@ rtl/core/wle_pkg.sv @@
package wle_pkg;

   localparam int MAX_POINTS_DEF = 64;
   localparam int WORD_W         = 32;
   localparam int IDX_W          = 7;
   localparam int OP_W           = 3;
   localparam int REQ_TDATA_W    = 104;
   localparam int RSP_TDATA_W    = 208;

   typedef enum logic [OP_W-1:0] {
      OP_START   = 3'd0,
      OP_SET_END = 3'd1,
      OP_INSERT  = 3'd2,
      OP_REMOVE  = 3'd3,
      OP_ADVANCE = 3'd4,
      OP_READ    = 3'd5
   } op_type;

   typedef enum logic [1:0] {
      STATUS_DONE      = 2'd0,
      STATUS_BAD_INDEX = 2'd1,
      STATUS_FULL      = 2'd2
   } status_type;

   // x in the lowest bits
   typedef struct packed {
      logic [WORD_W-1:0] t;
      logic [WORD_W-1:0] y;
      logic [WORD_W-1:0] x;
   } point_type;

   // point in the lowest bits, status on top
   typedef struct packed {
      status_type       status;
      logic [IDX_W-1:0] cursor;
      logic [IDX_W-1:0] point_count;
      point_type        end_pt;
      point_type        point;
   } result_type;

endpackage

@@ rtl/core/wle_store.sv @@
module wle_store
   import wle_pkg::*;
#(
   parameter int DEPTH = MAX_POINTS_DEF
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  point_type                wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output point_type                rdata
);

   point_type store_ff [DEPTH];
   point_type rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         store_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= store_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

@@ rtl/core/wle_ctrl.sv @@
module wle_ctrl
   import wle_pkg::*;
#(
   parameter int MAX_POINTS = MAX_POINTS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  op_type                        req_op,
   input  logic [IDX_W-1:0]              req_index,
   input  point_type                     req_point,
   input  logic                          slot_free,
   output logic                          res_valid,
   output result_type                    res,
   output logic                          mem_we,
   output logic [$clog2(MAX_POINTS)-1:0] mem_waddr,
   output point_type                     mem_wdata,
   output logic                          mem_re,
   output logic [$clog2(MAX_POINTS)-1:0] mem_raddr,
   input  point_type                     mem_rdata
);

   localparam int ADDR_W = $clog2(MAX_POINTS);
   localparam int CNT_W  = $clog2(MAX_POINTS + 1);
   localparam int CMP_W  = (CNT_W > IDX_W) ? CNT_W : IDX_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SHIFT_UP,
      ST_WRITE_NEW,
      ST_SHIFT_DN,
      ST_LOAD_END,
      ST_LOAD_CUR,
      ST_FINISH
   } state_type;

   state_type         state_ff,  state_in;
   op_type            op_ff,     op_in;
   logic [IDX_W-1:0]  idx_ff,    idx_in;
   point_type         coord_ff,  coord_in;
   logic [CNT_W-1:0]  count_ff,  count_in;
   logic [CNT_W-1:0]  cursor_ff, cursor_in;
   point_type         end_ff,    end_in;
   point_type         cur_ff,    cur_in;
   logic [ADDR_W-1:0] ptr_ff,    ptr_in;
   status_type        status_ff, status_in;
   logic              rd_hit_ff, rd_hit_in;

   logic [CMP_W-1:0]  idx_w;
   logic [CMP_W-1:0]  cnt_w;
   logic [ADDR_W-1:0] idx_a;
   logic [ADDR_W-1:0] last_a;

   assign idx_w  = CMP_W'(idx_ff);
   assign cnt_w  = CMP_W'(count_ff);
   assign idx_a  = ADDR_W'(idx_ff);
   assign last_a = ADDR_W'(count_ff - CNT_W'(1));

   assign req_ready = (state_ff == ST_IDLE) && !reset;

   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      idx_in    = idx_ff;
      coord_in  = coord_ff;
      count_in  = count_ff;
      cursor_in = cursor_ff;
      end_in    = end_ff;
      cur_in    = cur_ff;
      ptr_in    = ptr_ff;
      status_in = status_ff;
      rd_hit_in = rd_hit_ff;
      mem_we    = 1'b0;
      mem_waddr = '0;
      mem_wdata = coord_ff;
      mem_re    = 1'b0;
      mem_raddr = '0;
      res_valid = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_in    = req_op;
               idx_in   = req_index;
               coord_in = req_point;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            status_in = STATUS_DONE;
            rd_hit_in = 1'b0;
            state_in  = ST_FINISH;
            unique case (op_ff)
               OP_START: begin
                  mem_we    = 1'b1;
                  mem_waddr = '0;
                  count_in  = CNT_W'(1);
                  cursor_in = '0;
                  cur_in    = '0;
               end
               OP_SET_END: begin
                  end_in = coord_ff;
               end
               OP_INSERT: begin
                  if (idx_w == '0 || idx_w > cnt_w) begin
                     status_in = STATUS_BAD_INDEX;
                  end else if (count_ff == CNT_W'(MAX_POINTS)) begin
                     status_in = STATUS_FULL;
                  end else if (idx_w == cnt_w) begin
                     mem_we    = 1'b1;
                     mem_waddr = idx_a;
                     end_in    = coord_ff;
                     count_in  = count_ff + CNT_W'(1);
                  end else begin
                     mem_re    = 1'b1;
                     mem_raddr = last_a;
                     ptr_in    = last_a;
                     state_in  = ST_SHIFT_UP;
                  end
               end
               OP_REMOVE: begin
                  if (idx_w == '0 || idx_w >= cnt_w) begin
                     status_in = STATUS_BAD_INDEX;
                  end else if (idx_w + CMP_W'(1) < cnt_w) begin
                     mem_re    = 1'b1;
                     mem_raddr = idx_a + ADDR_W'(1);
                     ptr_in    = idx_a + ADDR_W'(1);
                     state_in  = ST_SHIFT_DN;
                  end else begin
                     mem_re    = 1'b1;
                     mem_raddr = ADDR_W'(count_ff - CNT_W'(2));
                     state_in  = ST_LOAD_END;
                  end
               end
               OP_ADVANCE: begin
                  if (cursor_ff + CNT_W'(1) < count_ff) begin
                     mem_re    = 1'b1;
                     mem_raddr = ADDR_W'(cursor_ff + CNT_W'(1));
                     cursor_in = cursor_ff + CNT_W'(1);
                     state_in  = ST_LOAD_CUR;
                  end
               end
               OP_READ: begin
                  if (idx_w < cnt_w) begin
                     mem_re    = 1'b1;
                     mem_raddr = idx_a;
                     rd_hit_in = 1'b1;
                  end
               end
               default: begin
               end
            endcase
         end
         ST_SHIFT_UP: begin
            mem_we    = 1'b1;
            mem_waddr = ptr_ff + ADDR_W'(1);
            mem_wdata = mem_rdata;
            if (ptr_ff == idx_a) begin
               state_in = ST_WRITE_NEW;
            end else begin
               mem_re    = 1'b1;
               mem_raddr = ptr_ff - ADDR_W'(1);
               ptr_in    = ptr_ff - ADDR_W'(1);
            end
         end
         ST_WRITE_NEW: begin
            mem_we    = 1'b1;
            mem_waddr = idx_a;
            count_in  = count_ff + CNT_W'(1);
            state_in  = ST_FINISH;
         end
         ST_SHIFT_DN: begin
            mem_we    = 1'b1;
            mem_waddr = ptr_ff - ADDR_W'(1);
            mem_wdata = mem_rdata;
            if (ptr_ff == last_a) begin
               count_in = count_ff - CNT_W'(1);
               state_in = ST_FINISH;
            end else begin
               mem_re    = 1'b1;
               mem_raddr = ptr_ff + ADDR_W'(1);
               ptr_in    = ptr_ff + ADDR_W'(1);
            end
         end
         ST_LOAD_END: begin
            end_in   = mem_rdata;
            count_in = count_ff - CNT_W'(1);
            state_in = ST_FINISH;
         end
         ST_LOAD_CUR: begin
            cur_in   = mem_rdata;
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (slot_free) begin
               res_valid = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // read data register holds through FINISH, no read is issued there
   always_comb begin
      res.point       = rd_hit_ff ? mem_rdata : cur_ff;
      res.end_pt      = end_ff;
      res.point_count = IDX_W'(count_ff);
      res.cursor      = IDX_W'(cursor_ff);
      res.status      = status_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         count_ff  <= '0;
         cursor_ff <= '0;
         end_ff    <= '0;
         cur_ff    <= '0;
         status_ff <= STATUS_DONE;
         rd_hit_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         cursor_ff <= cursor_in;
         end_ff    <= end_in;
         cur_ff    <= cur_in;
         status_ff <= status_in;
         rd_hit_ff <= rd_hit_in;
      end
      op_ff    <= op_in;
      idx_ff   <= idx_in;
      coord_ff <= coord_in;
      ptr_ff   <= ptr_in;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_POINTS))
      else $error("entry count above capacity");

   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff != ST_IDLE && state_ff != ST_FINISH))
      else $error("store written outside an operation");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      !reset |=> (count_ff == $past(count_ff)
                  || count_ff == $past(count_ff) + CNT_W'(1)
                  || count_ff == $past(count_ff) - CNT_W'(1)
                  || count_ff == CNT_W'(1)))
      else $error("entry count jumped");

endmodule

@@ rtl/core/waypoint_list_engine.sv @@
// Channel  Dir  Handshake           Contents
// req      in   req_tvalid/tready   tuser: operation; tdata: index, x, y, heading
// rsp      out  rsp_tvalid/tready   tdata: point, end point, count, cursor, status
//
// Start, set end, read, advance at the last entry: the request passes EXEC and FINISH,
// then the result is registered; a moving advance adds LOAD_CUR, removal of the last
// entry adds LOAD_END. Shifting insert adds one SHIFT_UP per moved entry and WRITE_NEW,
// shifting remove one SHIFT_DN each; one entry moves per cycle through the store's two ports.
// Reset clears count, cursor, end and current point; store contents stay unknown.
// req_tready is low in reset and during a request; a held result delays completion only.
module waypoint_list_engine
   import wle_pkg::*;
#(
   parameter int MAX_POINTS = MAX_POINTS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [OP_W-1:0]        req_tuser,  // operation
   input  logic [REQ_TDATA_W-1:0] req_tdata,  // index, coord_x, coord_y, coord_t, pad
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata   // point_x, point_y, point_t, end_x, end_y,
                                              // end_t, point_count, cursor, status
);

   localparam int ADDR_W = $clog2(MAX_POINTS);

   logic              slot_free;
   logic              res_valid;
   result_type        res;
   logic              mem_we;
   logic [ADDR_W-1:0] mem_waddr;
   point_type         mem_wdata;
   logic              mem_re;
   logic [ADDR_W-1:0] mem_raddr;
   point_type         mem_rdata;

   logic              rsp_valid_ff, rsp_valid_in;
   result_type        rsp_data_ff,  rsp_data_in;

   wle_store #(
      .DEPTH (MAX_POINTS)
   ) u_store (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .re    (mem_re),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   wle_ctrl #(
      .MAX_POINTS (MAX_POINTS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req_op    (op_type'(req_tuser)),
      .req_index (req_tdata[IDX_W-1:0]),
      .req_point (point_type'(req_tdata[IDX_W+3*WORD_W-1:IDX_W])),
      .slot_free (slot_free),
      .res_valid (res_valid),
      .res       (res),
      .mem_we    (mem_we),
      .mem_waddr (mem_waddr),
      .mem_wdata (mem_wdata),
      .mem_re    (mem_re),
      .mem_raddr (mem_raddr),
      .mem_rdata (mem_rdata)
   );

   assign slot_free    = !rsp_valid_ff || rsp_tready;
   assign rsp_valid_in = res_valid || (rsp_valid_ff && !rsp_tready);
   assign rsp_data_in  = res_valid ? res : rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

@@ tb/waypoint_list_engine_tb.sv @@
module waypoint_list_engine_tb;
   import wle_pkg::*;

   localparam logic [OP_W-1:0] OP_UNUSED_LO = 3'd6;
   localparam int CLOCK_PERIOD  = 12;
   localparam int RANDOM_ITEMS  = 1500;
   localparam int LIMIT_CYCLES  = 1_000_000;
   localparam int DRAIN_CYCLES  = 80;

   class waypoint_tracker;
      point_type  path [MAX_POINTS_DEF];
      logic [IDX_W-1:0] held = '0;
      logic [IDX_W-1:0] cur = '0;
      point_type  end_pt = '0;
      point_type  cur_pt = '0;
      result_type awaited [$];
      int mismatches = 0;
      int responses = 0;
      int peak = 0;
      int op_seen [8];
      int status_seen [4];

      function void note_request(logic [OP_W-1:0] op, logic [IDX_W-1:0] idx, point_type pt);
         result_type want;
         status_type st;
         int i;
         st = STATUS_DONE;
         case (op)
            OP_START: begin
               path[0] = pt;
               held = 1;
               cur = 0;
               cur_pt = '0;
            end
            OP_SET_END: end_pt = pt;
            OP_INSERT: begin
               if (idx == 0 || idx > held) begin
                  st = STATUS_BAD_INDEX;
               end else if (held >= MAX_POINTS_DEF) begin
                  st = STATUS_FULL;
               end else begin
                  if (idx == held) begin
                     end_pt = pt;
                  end else begin
                     for (i = held; i > idx; i--) path[i] = path[i-1];
                  end
                  path[idx] = pt;
                  held++;
               end
            end
            OP_REMOVE: begin
               if (idx == 0 || idx >= held) begin
                  st = STATUS_BAD_INDEX;
               end else begin
                  if (idx + 1 < held) begin
                     for (i = idx; i + 1 < held; i++) path[i] = path[i+1];
                  end else begin
                     end_pt = path[held-2];
                  end
                  held--;
               end
            end
            OP_ADVANCE: begin
               if (cur + 1 < held) begin
                  cur++;
                  cur_pt = path[cur];
               end
            end
            default: ;
         endcase
         want.point = (op == OP_READ && idx < held) ? path[idx] : cur_pt;
         want.end_pt = end_pt;
         want.point_count = held;
         want.cursor = cur;
         want.status = st;
         awaited.push_back(want);
         op_seen[op]++;
         status_seen[st]++;
         if (held > peak) peak = held;
      endfunction

      function void compare_word(string what, logic [31:0] got, logic [31:0] want);
         if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
               $display("response %0d %s: expected %h, got %h", responses, what, want, got);
         end
      endfunction

      function void check_response(logic [RSP_TDATA_W-1:0] data);
         result_type got, want;
         got = data;
         responses++;
         if (awaited.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("response %0d arrived with no request outstanding", responses);
            return;
         end
         want = awaited.pop_front();
         compare_word("point_x", got.point.x, want.point.x);
         compare_word("point_y", got.point.y, want.point.y);
         compare_word("point_t", got.point.t, want.point.t);
         compare_word("end_x", got.end_pt.x, want.end_pt.x);
         compare_word("end_y", got.end_pt.y, want.end_pt.y);
         compare_word("end_t", got.end_pt.t, want.end_pt.t);
         compare_word("point_count", got.point_count, want.point_count);
         compare_word("cursor", got.cursor, want.cursor);
         compare_word("status", got.status, want.status);
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [OP_W-1:0]        req_tuser = '0;        // operation
   logic [REQ_TDATA_W-1:0] req_tdata = '0;        // index, coord_x, coord_y, coord_t, pad
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;             // point, end point, count, cursor, status

   waypoint_tracker tracker = new;
   int send_idle_pct = 11;
   int recv_idle_pct = 47;
   int stall_left = 0;

   waypoint_list_engine dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // receiver; one long hold-off lets the block back up into the request side
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         tracker.check_response(rsp_tdata);
         if (tracker.responses == 700) stall_left = 400;
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   function automatic logic [31:0] rand_word();
      case ($urandom_range(9))
         0: return '0;
         1: return '1;
         default: return $urandom();
      endcase
   endfunction

   function automatic point_type rand_point();
      return {rand_word(), rand_word(), rand_word()};
   endfunction

   // mode 0 grows the path, 1 shrinks it, 2 mixes
   function automatic logic [OP_W-1:0] pick_operation(int mode);
      int unsigned edges [3][6] = '{'{70, 75, 85, 92, 96, 98},
                                    '{12, 62, 80, 90, 95, 97},
                                    '{30, 55, 75, 88, 94, 97}};
      op_type order [6] = '{OP_INSERT, OP_REMOVE, OP_READ, OP_ADVANCE, OP_SET_END, OP_START};
      int roll;
      roll = $urandom_range(99);
      if (tracker.held == 0 && roll < 90) return OP_START;
      for (int k = 0; k < 6; k++)
         if (roll < edges[mode][k]) return order[k];
      return OP_UNUSED_LO + 3'($urandom_range(1));
   endfunction

   function automatic logic [IDX_W-1:0] pick_index(logic [OP_W-1:0] op);
      int held;
      held = tracker.held;
      if ($urandom_range(99) < 15) return IDX_W'($urandom_range(MAX_POINTS_DEF));
      case (op)
         OP_INSERT: begin
            if (held == 0) return IDX_W'($urandom_range(MAX_POINTS_DEF));
            if ($urandom_range(4) == 0) return IDX_W'(held);
            return IDX_W'($urandom_range(held, 1));
         end
         OP_REMOVE: begin
            if (held < 2) return IDX_W'($urandom_range(MAX_POINTS_DEF));
            return IDX_W'($urandom_range(held - 1, 1));
         end
         OP_READ: begin
            if (held == 0) return IDX_W'($urandom_range(MAX_POINTS_DEF));
            return IDX_W'($urandom_range(held - 1, 0));
         end
         default: return IDX_W'($urandom_range(MAX_POINTS_DEF));
      endcase
   endfunction

   task automatic send_request(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
                               input point_type pt);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {1'b0, pt, idx};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      tracker.note_request(op, idx, pt);
   endtask

   initial begin
      #(CLOCK_PERIOD * LIMIT_CYCLES);
      $display("timed out with %0d results outstanding", tracker.awaited.size());
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      logic [OP_W-1:0] op;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // empty store
      send_request(OP_READ, 0, rand_point());
      send_request(OP_ADVANCE, 0, rand_point());
      send_request(OP_INSERT, 1, rand_point());
      send_request(OP_REMOVE, 0, rand_point());
      send_request(OP_UNUSED_LO, 64, '1);
      // build a short path
      send_request(OP_START, 0, '1);
      send_request(OP_SET_END, 0, {32'hA5A5A5A5, 32'h5A5A5A5A, 32'h0F0F0F0F});
      send_request(OP_INSERT, 0, rand_point());
      send_request(OP_INSERT, 1, '0);
      send_request(OP_INSERT, 1, rand_point());
      send_request(OP_INSERT, 64, rand_point());
      send_request(OP_INSERT, 3, rand_point());
      send_request(OP_READ, 0, rand_point());
      send_request(OP_READ, 64, rand_point());
      // walk to the last entry and try once more
      repeat (4) send_request(OP_ADVANCE, 0, rand_point());
      send_request(OP_REMOVE, 4, rand_point());
      send_request(OP_REMOVE, 0, rand_point());
      send_request(OP_REMOVE, 3, rand_point());
      send_request(OP_REMOVE, 1, rand_point());
      send_request(OP_READ, 1, rand_point());
      send_request(OP_UNUSED_LO + 3'd1, 0, '0);
      send_request(OP_START, 0, '0);
      send_request(OP_SET_END, 0, '1);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == RANDOM_ITEMS / 3) begin
            send_idle_pct = 47;
            recv_idle_pct = 11;
         end
         if (n == 2 * RANDOM_ITEMS / 3) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         op = pick_operation((n / 120) % 3);
         send_request(op, pick_index(op), rand_point());
      end
      req_tvalid <= 1'b0;

      while (tracker.awaited.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d requests: start %0d, end %0d, ins %0d, rem %0d, adv %0d, read %0d, other %0d",
               tracker.responses, tracker.op_seen[OP_START], tracker.op_seen[OP_SET_END],
               tracker.op_seen[OP_INSERT], tracker.op_seen[OP_REMOVE],
               tracker.op_seen[OP_ADVANCE], tracker.op_seen[OP_READ],
               tracker.op_seen[OP_UNUSED_LO] + tracker.op_seen[OP_UNUSED_LO + 3'd1]);
      $display("done %0d, bad index %0d, full %0d; longest path %0d; mismatches %0d",
               tracker.status_seen[STATUS_DONE], tracker.status_seen[STATUS_BAD_INDEX],
               tracker.status_seen[STATUS_FULL], tracker.peak, tracker.mismatches);
      if (tracker.mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/core/wle_pkg.sv
rtl/core/wle_store.sv
rtl/core/wle_ctrl.sv
rtl/core/waypoint_list_engine.sv
tb/waypoint_list_engine_tb.sv
